// ===== design/usb_in_data_packetizer_defines.svh =====
// Assertion macros for the USB IN data packetizer.
// Used by the top level; assumes clock aclk and active-low reset aresetn in scope.
`ifndef USB_IN_DATA_PACKETIZER_DEFINES_SVH
`define USB_IN_DATA_PACKETIZER_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define USBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("usbp: same-cycle check failed");

// Check a consequence in the cycle after its condition.
`define USBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("usbp: next-cycle check failed");

`endif

// ===== design/usbp_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the USB IN data packetizer.
// No dependencies; the framer, serializer and top level refer to it by scoped names.
package usbp_pkg;

    // Sizing
    localparam int MAX_PACKET_BYTES = 8;
    localparam int ENDPOINT_COUNT   = 2;
    localparam int EP_W             = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
    localparam int BIP_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int MAX_RESULTS      = 7;
    localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
    localparam int LEN_W            = 4;
    localparam int PKT_OVERHEAD     = 3;

    // Protocol constants
    localparam logic [7:0]  PID_DATA1  = 8'h4B;
    localparam logic [7:0]  PID_TOGGLE = 8'h88;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // Item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_EMPTY   = 1'b1;

    typedef struct packed {
        logic       kind;
        logic       endpoint;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       send_short;
        logic       force_data1;
    } in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             packet_start;
        logic             packet_end;
        logic [LEN_W-1:0] packet_length;
        logic             transfer_end;
    } out_t;

    // All result bytes caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]             count;
        out_t [MAX_RESULTS-1:0]       slots;
    } frame_t;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/usbp_framer.sv =====
// Packet framer: keeps per-endpoint PID toggles, CRC and packet fill, and builds
// every result byte of one item in a single pass. Depends on usbp_pkg.
module usbp_framer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    output logic             item_ready,
    input  usbp_pkg::in_t    item,
    output logic             frame_valid,
    input  logic             frame_ready,
    output usbp_pkg::frame_t frame
);

    logic [7:0]                  data_pid_reg  [usbp_pkg::ENDPOINT_COUNT];
    logic [7:0]                  data_pid_next [usbp_pkg::ENDPOINT_COUNT];
    logic [15:0]                 crc_reg, crc_next;
    logic [usbp_pkg::BIP_W-1:0]  bip_reg, bip_next;
    logic                        in_transfer_reg, in_transfer_next;
    logic [usbp_pkg::EP_W-1:0]   cur_ep_reg, cur_ep_next;
    logic                        accept;

    function automatic usbp_pkg::out_t mk_out(input logic [7:0] b, input logic st,
                                              input logic en,
                                              input logic [usbp_pkg::LEN_W-1:0] len,
                                              input logic te);
        usbp_pkg::out_t o;
        o.out_byte      = b;
        o.packet_start  = st;
        o.packet_end    = en;
        o.packet_length = len;
        o.transfer_end  = te;
        return o;
    endfunction

    function automatic logic [usbp_pkg::EP_W-1:0] sel_ep(input logic e);
        logic [usbp_pkg::EP_W-1:0] r;
        if (int'(e) >= usbp_pkg::ENDPOINT_COUNT) begin
            r = usbp_pkg::EP_W'(usbp_pkg::ENDPOINT_COUNT - 1);
        end else begin
            r = usbp_pkg::EP_W'(e);
        end
        return r;
    endfunction

    assign frame_valid = item_valid;
    assign item_ready  = frame_ready;
    assign accept      = item_valid && frame_ready;

    // Build the result bytes and the next state for the item at the input
    always_comb begin
        logic [usbp_pkg::CNT_W-1:0] n;
        logic [usbp_pkg::EP_W-1:0]  ep;
        logic [7:0]                 pid_cur;
        logic [7:0]                 pid_pkt;
        logic                       first;
        logic [usbp_pkg::BIP_W-1:0] bip_cur;
        logic [usbp_pkg::BIP_W-1:0] bip_inc;
        logic [15:0]                crc_cur;
        logic [15:0]                crc_upd;
        logic [15:0]                crc_fin;
        logic                       full;
        logic                       zlp;
        logic [usbp_pkg::LEN_W-1:0] zlp_len;

        n                = '0;
        frame            = '0;
        crc_next         = crc_reg;
        bip_next         = bip_reg;
        in_transfer_next = in_transfer_reg;
        cur_ep_next      = cur_ep_reg;
        data_pid_next    = data_pid_reg;
        ep               = in_transfer_reg ? cur_ep_reg : sel_ep(item.endpoint);
        pid_cur          = data_pid_reg[ep];
        pid_pkt          = pid_cur;
        first            = 1'b0;
        bip_cur          = '0;
        bip_inc          = '0;
        crc_cur          = crc_reg;
        crc_upd          = crc_reg;
        crc_fin          = '0;
        full             = 1'b0;
        zlp              = 1'b0;
        zlp_len          = usbp_pkg::LEN_W'(usbp_pkg::PKT_OVERHEAD);

        if (item.kind == usbp_pkg::KIND_EMPTY) begin
            // Empty transfer: optional zero-length packet, ignored while a transfer is open
            if (!in_transfer_reg && (item.force_data1 || item.send_short)) begin
                pid_pkt = item.force_data1 ? usbp_pkg::PID_DATA1
                                           : (pid_cur ^ usbp_pkg::PID_TOGGLE);
                data_pid_next[ep] = pid_pkt;
                frame.slots[n] = mk_out(pid_pkt, 1'b1, 1'b0, '0, 1'b0);
                n = n + 1'b1;
                frame.slots[n] = mk_out(8'h00, 1'b0, 1'b0, '0, 1'b0);
                n = n + 1'b1;
                frame.slots[n] = mk_out(8'h00, 1'b0, 1'b1, zlp_len, 1'b1);
                n = n + 1'b1;
                crc_next = usbp_pkg::CRC_INIT;
                bip_next = '0;
            end
        end else begin
            first   = !in_transfer_reg && (ep == '0);
            bip_cur = in_transfer_reg ? bip_reg : '0;

            // Open a packet with its PID
            if (bip_cur == '0) begin
                pid_pkt = first ? usbp_pkg::PID_DATA1 : (pid_cur ^ usbp_pkg::PID_TOGGLE);
                crc_cur = usbp_pkg::CRC_INIT;
                frame.slots[n] = mk_out(pid_pkt, 1'b1, 1'b0, '0, 1'b0);
                n = n + 1'b1;
            end

            // Payload byte
            crc_upd = usbp_pkg::crc_byte(crc_cur, item.data_byte);
            bip_inc = bip_cur + 1'b1;
            frame.slots[n] = mk_out(item.data_byte, 1'b0, 1'b0, '0, 1'b0);
            n = n + 1'b1;

            full             = bip_inc >= usbp_pkg::BIP_W'(usbp_pkg::MAX_PACKET_BYTES);
            zlp              = item.last_byte && full && item.send_short;
            crc_next         = crc_upd;
            bip_next         = bip_inc;
            in_transfer_next = 1'b1;
            cur_ep_next      = ep;

            // Close the packet with the complemented CRC, low byte first
            if (full || item.last_byte) begin
                crc_fin = ~crc_upd;
                frame.slots[n] = mk_out(crc_fin[7:0], 1'b0, 1'b0, '0, 1'b0);
                n = n + 1'b1;
                frame.slots[n] = mk_out(crc_fin[15:8], 1'b0, 1'b1,
                    usbp_pkg::LEN_W'(int'(bip_inc) + usbp_pkg::PKT_OVERHEAD),
                    item.last_byte && !zlp);
                n = n + 1'b1;
                crc_next = usbp_pkg::CRC_INIT;
                bip_next = '0;

                // Trailing zero-length packet after a full last packet
                if (zlp) begin
                    pid_pkt = pid_pkt ^ usbp_pkg::PID_TOGGLE;
                    frame.slots[n] = mk_out(pid_pkt, 1'b1, 1'b0, '0, 1'b0);
                    n = n + 1'b1;
                    frame.slots[n] = mk_out(8'h00, 1'b0, 1'b0, '0, 1'b0);
                    n = n + 1'b1;
                    frame.slots[n] = mk_out(8'h00, 1'b0, 1'b1, zlp_len, 1'b1);
                    n = n + 1'b1;
                end
                if (item.last_byte) begin
                    in_transfer_next = 1'b0;
                end
            end
            data_pid_next[ep] = pid_pkt;
        end
        frame.count = n;
    end

    // Advance the framing state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < usbp_pkg::ENDPOINT_COUNT; i++) begin
                data_pid_reg[i] <= usbp_pkg::PID_DATA1;
            end
            crc_reg         <= usbp_pkg::CRC_INIT;
            bip_reg         <= '0;
            in_transfer_reg <= 1'b0;
            cur_ep_reg      <= '0;
        end else if (accept) begin
            data_pid_reg    <= data_pid_next;
            crc_reg         <= crc_next;
            bip_reg         <= bip_next;
            in_transfer_reg <= in_transfer_next;
            cur_ep_reg      <= cur_ep_next;
        end
    end

endmodule

// ===== design/usbp_serializer.sv =====
// Result buffer: holds the bytes of one framed item and hands them out one per
// transaction. Depends on usbp_pkg.
module usbp_serializer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             frame_valid,
    output logic             frame_ready,
    input  usbp_pkg::frame_t frame,
    output logic             m_valid,
    input  logic             m_ready,
    output usbp_pkg::out_t   m_item
);

    usbp_pkg::frame_t           frame_reg;
    logic [usbp_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       busy_reg, busy_next;
    logic                       last_slot;
    logic                       load;

    assign last_slot   = usbp_pkg::CNT_W'(idx_reg + 1'b1) == frame_reg.count;
    assign frame_ready = !busy_reg || (m_ready && last_slot);
    assign load        = frame_valid && frame_ready && (frame.count != '0);
    assign m_valid     = busy_reg;
    assign m_item      = frame_reg.slots[idx_reg];

    // Step through the buffer; load when idle or as the last byte leaves
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (busy_reg && m_ready) begin
            if (last_slot) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Capture the frame payload
    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame;
        end
    end

endmodule

// ===== design/usb_in_data_packetizer.sv =====
// Top level of the USB IN data packetizer: input register, framer, result buffer.
// Depends on usbp_pkg, usbp_framer, usbp_serializer and usb_in_data_packetizer_defines.svh.

// Takes payload bytes for the IN endpoints one transaction at a time and returns the packet
// stream: PID, up to eight payload bytes, then the complemented CRC-16 low and high bytes,
// with optional zero-length packets. An item is registered on entry and framed in one pass
// from the input register; the result bytes are captured in the result buffer, which
// offers them. The result buffer sends one byte per cycle while m_ready is high, and takes
// the next framed item only when idle or as its last byte leaves; an item yields one to
// seven bytes, or none. Mid-packet payload bytes flow at one item per cycle while m_ready
// is high, and a packet of n payload bytes is n + 3 bytes long. While earlier bytes still wait
// on m_ready, the block takes one further item into its input register and then stalls.
`include "usb_in_data_packetizer_defines.svh"

module usb_in_data_packetizer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  usbp_pkg::in_t  s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output usbp_pkg::out_t m_item
);

    usbp_pkg::in_t    in_item_reg;
    logic             in_valid_reg;
    logic             fr_ready;
    logic             frame_valid;
    logic             frame_ready;
    usbp_pkg::frame_t frame;

    // Input register: refill when empty or whenever the framer takes the held item
    assign s_ready = !in_valid_reg || fr_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    usbp_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (in_valid_reg),
        .item_ready  (fr_ready),
        .item        (in_item_reg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    usbp_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // Held item stays put while the framer is blocked
    `USBP_ASSERT_NEXT(a_in_hold, in_valid_reg && !fr_ready, in_valid_reg && $stable(in_item_reg))
    // Only a packet's closing byte carries a length
    `USBP_ASSERT_SAME(a_len_on_end, m_valid && !m_item.packet_end, m_item.packet_length == '0)
    // A transfer ends only on a packet's closing byte
    `USBP_ASSERT_SAME(a_te_on_end, m_valid && m_item.transfer_end, m_item.packet_end)
    // A PID byte never closes a packet
    `USBP_ASSERT_SAME(a_pid_not_end, m_valid && m_item.packet_start, !m_item.packet_end)

endmodule

// ===== test/tb.sv =====
// Testbench for usb_in_data_packetizer: random transfers framed into USB data packets.
// Depends on usbp_pkg for the item types; a scoreboard class predicts every packet byte.
`timescale 1ns / 100ps

module tb;

    // Predicts the packet byte stream and checks each transaction on the result side
    class usb_packet_scoreboard;
        localparam logic [7:0]  DATA1_PID  = 8'h4B;
        localparam logic [7:0]  PID_FLIP   = 8'h88;
        localparam logic [15:0] CRC_SEED   = 16'hFFFF;
        localparam logic [15:0] CRC16_POLY = 16'hA001;

        logic [7:0]     ep_pid [usbp_pkg::ENDPOINT_COUNT];
        logic [15:0]    crc;
        int             fill;
        bit             xfer_open;
        int             cur_ep;
        usbp_pkg::out_t expected_bytes [$];
        int             failures;

        function new();
            foreach (ep_pid[i]) ep_pid[i] = DATA1_PID;
            crc       = CRC_SEED;
            fill      = 0;
            xfer_open = 1'b0;
            cur_ep    = 0;
            failures  = 0;
        endfunction

        // Shift the data in LSB first, one bit per step
        function logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
            bit fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ CRC16_POLY;
                end
            end
            return c;
        endfunction

        // Saturate endpoint numbers above the implemented range
        function int ep_index(logic e);
            if (int'(e) >= usbp_pkg::ENDPOINT_COUNT) begin
                return usbp_pkg::ENDPOINT_COUNT - 1;
            end
            return int'(e);
        endfunction

        function void add_byte(logic [7:0] b, bit st, bit en, int len, bit te);
            usbp_pkg::out_t o;
            o.out_byte      = b;
            o.packet_start  = st;
            o.packet_end    = en;
            o.packet_length = len[usbp_pkg::LEN_W-1:0];
            o.transfer_end  = te;
            expected_bytes.push_back(o);
        endfunction

        // Append the complemented CRC, low byte first, and restart the packet
        function void close_packet(bit te);
            logic [15:0] c;
            c = ~crc;
            add_byte(c[7:0], 1'b0, 1'b0, 0, 1'b0);
            add_byte(c[15:8], 1'b0, 1'b1, fill + 3, te);
            crc  = CRC_SEED;
            fill = 0;
        endfunction

        function void zero_packet(logic [7:0] pid);
            add_byte(pid, 1'b1, 1'b0, 0, 1'b0);
            crc  = CRC_SEED;
            fill = 0;
            close_packet(1'b1);
        endfunction

        // Work out the bytes that one accepted transaction causes
        function void note_input(usbp_pkg::in_t it);
            int ep;
            bit first;
            bit full;
            bit zlp;
            first = 1'b0;
            if (it.kind == usbp_pkg::KIND_EMPTY) begin
                // Drop empty items while a transfer is open
                if (xfer_open) begin
                    return;
                end
                ep = ep_index(it.endpoint);
                if (it.force_data1) begin
                    ep_pid[ep] = DATA1_PID;
                    zero_packet(ep_pid[ep]);
                end else if (it.send_short) begin
                    ep_pid[ep] = ep_pid[ep] ^ PID_FLIP;
                    zero_packet(ep_pid[ep]);
                end
                return;
            end
            // Latch the endpoint at the start of a transfer
            if (!xfer_open) begin
                cur_ep    = ep_index(it.endpoint);
                xfer_open = 1'b1;
                fill      = 0;
                first     = (cur_ep == 0);
            end
            if (fill == 0) begin
                ep_pid[cur_ep] = first ? DATA1_PID : (ep_pid[cur_ep] ^ PID_FLIP);
                crc = CRC_SEED;
                add_byte(ep_pid[cur_ep], 1'b1, 1'b0, 0, 1'b0);
            end
            crc  = crc_add(crc, it.data_byte);
            fill = fill + 1;
            add_byte(it.data_byte, 1'b0, 1'b0, 0, 1'b0);
            full = (fill >= usbp_pkg::MAX_PACKET_BYTES);
            if (full || it.last_byte) begin
                zlp = it.last_byte && full && it.send_short;
                close_packet(it.last_byte && !zlp);
                if (zlp) begin
                    ep_pid[cur_ep] = ep_pid[cur_ep] ^ PID_FLIP;
                    zero_packet(ep_pid[cur_ep]);
                end
                if (it.last_byte) begin
                    xfer_open = 1'b0;
                end
            end
        endfunction

        // Compare one result transaction with the oldest expected byte
        function void check_result(usbp_pkg::out_t got);
            usbp_pkg::out_t exp_b;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected packet byte %h start=%b end=%b len=%0d xend=%b",
                         $time, got.out_byte, got.packet_start, got.packet_end,
                         got.packet_length, got.transfer_end);
                failures++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (got !== exp_b) begin
                $display("%0t: mismatch expected byte=%h start=%b end=%b len=%0d xend=%b",
                         $time, exp_b.out_byte, exp_b.packet_start, exp_b.packet_end,
                         exp_b.packet_length, exp_b.transfer_end);
                $display("%0t:          actual   byte=%h start=%b end=%b len=%0d xend=%b",
                         $time, got.out_byte, got.packet_start, got.packet_end,
                         got.packet_length, got.transfer_end);
                failures++;
            end
        endfunction
    endclass

    logic           aclk;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    usbp_pkg::in_t  s_item  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    usbp_pkg::out_t m_item;

    usb_packet_scoreboard sb = new();

    int burst_left = 0;
    int ready_run  = 0;
    bit ready_level;
    int items_sent = 0;

    usb_in_data_packetizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop for a hung run
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Record accepted items and check each result transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_item);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_item);
            end
        end
    end

    // Receiver: long ready stretches, choppy stretches and stalls
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    ready_level = 1'b1;
                    ready_run   = $urandom_range(20, 60);
                end
                3, 4, 5, 6: begin
                    ready_level = 1'b1;
                    ready_run   = $urandom_range(1, 5);
                end
                default: begin
                    ready_level = 1'b0;
                    ready_run   = $urandom_range(1, 6);
                end
            endcase
        end
        ready_run = ready_run - 1;
        m_ready <= ready_level;
    end

    function automatic usbp_pkg::in_t make_item(logic kind, logic ep, logic [7:0] data,
                                                logic last, logic shortp, logic force1);
        usbp_pkg::in_t it;
        it.kind        = kind;
        it.endpoint    = ep;
        it.data_byte   = data;
        it.last_byte   = last;
        it.send_short  = shortp;
        it.force_data1 = force1;
        return it;
    endfunction

    // Offer one transaction; valid is lowered only when a burst ends
    task automatic drive_item(usbp_pkg::in_t it);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left = burst_left - 1;
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
        end
    endtask

    // Hold the sender until every expected byte has come out
    task automatic wait_drain();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
        // Let the monitor note the last accepted transaction first
        @(posedge aclk);
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
    endtask

    // Send one payload transfer with ignored noise in the unused fields
    task automatic send_transfer(logic ep, int len, logic zlp);
        logic last;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            drive_item(make_item(usbp_pkg::KIND_PAYLOAD,
                                 (i > 0 && $urandom_range(0, 4) == 0) ? ~ep : ep,
                                 8'($urandom), last,
                                 last ? zlp : 1'($urandom), 1'($urandom)));
            // Slip in an empty item that an open transfer ignores
            if (!last && $urandom_range(0, 15) == 0) begin
                drive_item(make_item(usbp_pkg::KIND_EMPTY, 1'($urandom), 8'($urandom),
                                     1'($urandom), 1'($urandom), 1'($urandom)));
            end
        end
    endtask

    initial begin
        logic [7:0] pattern [8];
        int         len;
        pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};

        // Reset
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty items: no flags, forced DATA1, toggled zero-length packet
        drive_item(make_item(usbp_pkg::KIND_EMPTY, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        drive_item(make_item(usbp_pkg::KIND_EMPTY, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b1));
        drive_item(make_item(usbp_pkg::KIND_EMPTY, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0));
        // One-byte transfers; endpoint 0 starts with DATA1
        drive_item(make_item(usbp_pkg::KIND_PAYLOAD, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
        drive_item(make_item(usbp_pkg::KIND_PAYLOAD, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0));
        // Full packet closed by a zero-length packet, with endpoint change and empty item
        for (int i = 0; i < 8; i++) begin
            drive_item(make_item(usbp_pkg::KIND_PAYLOAD, (i == 3) ? 1'b0 : 1'b1, pattern[i],
                                 i == 7, 1'b1, 1'b0));
            if (i == 4) begin
                drive_item(make_item(usbp_pkg::KIND_EMPTY, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
            end
        end
        // Zero-length packet on endpoint 0 after data toggles
        drive_item(make_item(usbp_pkg::KIND_EMPTY, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
        // Full packet on endpoint 0 ending the transfer without a zero-length packet
        for (int i = 0; i < 8; i++) begin
            drive_item(make_item(usbp_pkg::KIND_PAYLOAD, 1'b0, ~pattern[i], i == 7,
                                 1'b0, 1'b1));
        end
        wait_drain();

        // Random transfers and empty items
        while (items_sent < 136) begin
            if ($urandom_range(0, 19) == 0) begin
                wait_drain();
            end
            if ($urandom_range(0, 4) == 0) begin
                drive_item(make_item(usbp_pkg::KIND_EMPTY, 1'($urandom), 8'($urandom),
                                     1'($urandom), 1'($urandom),
                                     $urandom_range(0, 2) == 0));
                items_sent = items_sent + 1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: len = $urandom_range(1, 7);
                    5, 6:          len = ($urandom_range(0, 1) == 0) ? 8 : 16;
                    default:       len = $urandom_range(9, 20);
                endcase
                send_transfer(1'($urandom), len, 1'($urandom));
                items_sent = items_sent + len;
            end
        end

        // Let the last results out, then a margin for any stray bytes
        wait_drain();
        repeat (20) @(posedge aclk);
        if (sb.failures == 0 && sb.expected_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== usb_in_data_packetizer.f =====
+incdir+design
design/usbp_pkg.sv
design/usbp_framer.sv
design/usbp_serializer.sv
design/usb_in_data_packetizer.sv
test/tb.sv
